/* hw/rtl/ara_pkg.sv */
`timescale 1ns / 1ps
package ara_pkg;

   localparam int OUT_WIDTH = 63;

   localparam logic [2:0] REG_LOW_FIXED     = 3'd0;
   localparam logic [2:0] REG_LOW_VALUE     = 3'd1;
   localparam logic [2:0] REG_HIGH_FIXED    = 3'd2;
   localparam logic [2:0] REG_HIGH_VALUE    = 3'd3;
   localparam logic [2:0] REG_QUANTUM_FIXED = 3'd4;
   localparam logic [2:0] REG_QUANTUM_VALUE = 3'd5;

   localparam logic signed [63:0] ONE_Q16     = 64'sd65536;
   localparam logic signed [63:0] SCALE_LIMIT = 64'sd655360;
   localparam logic [2:0]         MAX_EXP     = 3'd6;
   localparam logic [1:0]         MAX_PASS    = 2'd2;
   localparam logic [5:0]         REM_STEPS   = 6'd63;

   localparam logic signed [67:0] SAT_HI = 68'sh03FFFFFFFFFFFFFFF;
   localparam logic signed [67:0] SAT_LO = 68'shFC000000000000000;

   typedef struct packed {
      logic        start;
      logic [62:0] dividend;
      logic [62:0] divisor;
   } ara_rem_req_type;

   typedef struct packed {
      logic        done;
      logic [62:0] rem;
   } ara_rem_rsp_type;

   function automatic logic signed [63:0] sat68(input logic signed [67:0] p);
      if (p > SAT_HI) return SAT_HI[63:0];
      if (p < SAT_LO) return SAT_LO[63:0];
      return p[63:0];
   endfunction

   function automatic logic signed [67:0] ext68(input logic signed [63:0] x);
      return {{4{x[63]}}, x};
   endfunction

   // saturating multiply by ten, shift and add
   function automatic logic signed [63:0] sat10(input logic signed [63:0] x);
      logic signed [67:0] xe;
      xe = ext68(x);
      return sat68((xe <<< 3) + (xe <<< 1));
   endfunction

   function automatic logic [62:0] mag63(input logic signed [63:0] x);
      logic [63:0] m;
      m = x[63] ? 64'(-x) : 64'(x);
      return m[62:0];
   endfunction

endpackage

/* hw/rtl/ara_rem_unit.sv */
`timescale 1ns / 1ps
module ara_rem_unit
   import ara_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  ara_rem_req_type req,
   output ara_rem_rsp_type rsp
);

   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic [62:0] rem_ff, rem_in;
   logic [62:0] dvd_ff, dvd_in;
   logic [62:0] dvs_ff, dvs_in;
   logic [63:0] trial;

   // restoring remainder, one dividend bit per cycle
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      dvd_in  = dvd_ff;
      dvs_in  = dvs_ff;
      trial   = {rem_ff, dvd_ff[62]};
      if (req.start) begin
         busy_in = 1'b1;
         cnt_in  = REM_STEPS;
         rem_in  = '0;
         dvd_in  = req.dividend;
         dvs_in  = req.divisor;
      end else if (busy_ff) begin
         if (trial >= {1'b0, dvs_ff}) begin
            rem_in = 63'(trial - {1'b0, dvs_ff});
         end else begin
            rem_in = trial[62:0];
         end
         dvd_in = {dvd_ff[61:0], 1'b0};
         cnt_in = cnt_ff - 6'd1;
         if (cnt_ff == 6'd1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      dvd_ff <= dvd_in;
      dvs_ff <= dvs_in;
   end

   assign rsp.done = done_ff;
   assign rsp.rem  = rem_ff;

endmodule

/* hw/rtl/ara_minmax.sv */
`timescale 1ns / 1ps
module ara_minmax #(
   parameter int SAMPLE_WIDTH = 32
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           take,
   input  logic signed [SAMPLE_WIDTH-1:0] sample,
   input  logic                           last,
   input  logic                           low_fixed,
   input  logic                           high_fixed,
   output logic signed [SAMPLE_WIDTH-1:0] min_now,
   output logic signed [SAMPLE_WIDTH-1:0] max_now
);

   localparam logic signed [SAMPLE_WIDTH-1:0] POS_MAX = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
   localparam logic signed [SAMPLE_WIDTH-1:0] NEG_MAX = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};

   logic signed [SAMPLE_WIDTH-1:0] min_ff, min_in;
   logic signed [SAMPLE_WIDTH-1:0] max_ff, max_in;

   // values including the item being taken
   assign min_now = (!low_fixed && sample < min_ff) ? sample : min_ff;
   assign max_now = (!high_fixed && sample > max_ff) ? sample : max_ff;

   always_comb begin
      min_in = min_ff;
      max_in = max_ff;
      if (take) begin
         min_in = last ? POS_MAX : min_now;
         max_in = last ? NEG_MAX : max_now;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         min_ff <= POS_MAX;
         max_ff <= NEG_MAX;
      end else begin
         min_ff <= min_in;
         max_ff <= max_in;
      end
   end

endmodule

/* hw/rtl/axis_range_autoscale.sv */
`timescale 1ns / 1ps
// samples: one item per cycle while idle with no result waiting, only the running min and max are updated
// last item: with a fixed step the result skips the scaling and remainder steps; otherwise
// its timing is set by the serial remainder unit (up to two per pass, up to three passes)
// and the x10 loops
// result is held in an output register; no item is taken while it waits
// synchronous reset clears control and config registers to zero and min/max to their extremes
module axis_range_autoscale
   import ara_pkg::*;
#(
   parameter int SAMPLE_WIDTH = 32
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic signed [SAMPLE_WIDTH-1:0] req_sample_value,
   input  logic                           req_last_sample,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic signed [OUT_WIDTH-1:0]    rsp_axis_low,
   output logic signed [OUT_WIDTH-1:0]    rsp_axis_high,
   output logic signed [OUT_WIDTH-1:0]    rsp_tick_step,
   output logic [2:0]                     rsp_scale_exponent,
   output logic                           rsp_range_error,
   input  logic                           csr_we,
   input  logic [2:0]                     csr_index,
   input  logic [SAMPLE_WIDTH-1:0]        csr_wdata
);

   localparam logic [3:0] S_IDLE   = 4'd0;
   localparam logic [3:0] S_SETUP  = 4'd1;
   localparam logic [3:0] S_INIT   = 4'd2;
   localparam logic [3:0] S_SCALE  = 4'd3;
   localparam logic [3:0] S_RSRCH  = 4'd4;
   localparam logic [3:0] S_HSTART = 4'd5;
   localparam logic [3:0] S_HWAIT  = 4'd6;
   localparam logic [3:0] S_LSTART = 4'd7;
   localparam logic [3:0] S_LWAIT  = 4'd8;
   localparam logic [3:0] S_CHECK  = 4'd9;
   localparam logic [3:0] S_FIN    = 4'd10;

   logic                    low_fixed_ff, high_fixed_ff, quantum_fixed_ff;
   logic [SAMPLE_WIDTH-1:0] low_value_ff, high_value_ff, quantum_value_ff;

   logic [3:0]         state_ff, state_in;
   logic signed [63:0] lo_ff, lo_in, hi_ff, hi_in;
   logic               lof_ff, lof_in, hif_ff, hif_in, swp_ff, swp_in;
   logic signed [63:0] d_ff, d_in, r_ff, r_in, l_ff, l_in, h_ff, h_in;
   logic signed [63:0] zl_ff, zl_in, zh_ff, zh_in;
   logic [2:0]         e_ff, e_in;
   logic [1:0]         pass_ff, pass_in;
   logic               err_ff, err_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic signed [OUT_WIDTH-1:0] out_low_ff, out_low_in, out_high_ff, out_high_in;
   logic signed [OUT_WIDTH-1:0] out_step_ff, out_step_in;
   logic [2:0]         out_exp_ff, out_exp_in;
   logic               out_err_ff, out_err_in;

   logic signed [SAMPLE_WIDTH-1:0] min_now, max_now;
   logic               take;
   ara_rem_req_type    rem_req;
   ara_rem_rsp_type    rem_rsp;

   logic signed [63:0] r10, r5, r2, qv;
   logic signed [67:0] ax, rx, remx, delta_q;

   assign take      = req_valid && req_ready;
   assign req_ready = (state_ff == S_IDLE) && !rsp_valid_ff;

   ara_minmax #(.SAMPLE_WIDTH(SAMPLE_WIDTH)) u_minmax (
      .clock      (clock),
      .reset      (reset),
      .take       (take),
      .sample     (req_sample_value),
      .last       (req_last_sample),
      .low_fixed  (low_fixed_ff),
      .high_fixed (high_fixed_ff),
      .min_now    (min_now),
      .max_now    (max_now)
   );

   ara_rem_unit u_rem (
      .clock (clock),
      .reset (reset),
      .req   (rem_req),
      .rsp   (rem_rsp)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         low_fixed_ff     <= 1'b0;
         high_fixed_ff    <= 1'b0;
         quantum_fixed_ff <= 1'b0;
         low_value_ff     <= '0;
         high_value_ff    <= '0;
         quantum_value_ff <= '0;
      end else if (csr_we) begin
         case (csr_index)
            REG_LOW_FIXED:     low_fixed_ff     <= csr_wdata[0];
            REG_LOW_VALUE:     low_value_ff     <= csr_wdata;
            REG_HIGH_FIXED:    high_fixed_ff    <= csr_wdata[0];
            REG_HIGH_VALUE:    high_value_ff    <= csr_wdata;
            REG_QUANTUM_FIXED: quantum_fixed_ff <= csr_wdata[0];
            REG_QUANTUM_VALUE: quantum_value_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign r2   = r_ff <<< 1;
   assign r5   = (r_ff <<< 2) + r_ff;
   assign r10  = r5 <<< 1;
   assign qv   = {{(64-SAMPLE_WIDTH){quantum_value_ff[SAMPLE_WIDTH-1]}}, quantum_value_ff};
   assign rx   = ext68(r_ff);
   assign remx = {5'd0, rem_rsp.rem};
   assign delta_q = ext68(hi_ff) - ext68(lo_ff);

   always_comb begin
      ax = (state_ff == S_HWAIT) ? ext68(h_ff) : ext68(l_ff);
   end

   always_comb begin
      state_in     = state_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      lof_in       = lof_ff;
      hif_in       = hif_ff;
      swp_in       = swp_ff;
      d_in         = d_ff;
      r_in         = r_ff;
      l_in         = l_ff;
      h_in         = h_ff;
      zl_in        = zl_ff;
      zh_in        = zh_ff;
      e_in         = e_ff;
      pass_in      = pass_ff;
      err_in       = err_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      out_low_in   = out_low_ff;
      out_high_in  = out_high_ff;
      out_step_in  = out_step_ff;
      out_exp_in   = out_exp_ff;
      out_err_in   = out_err_ff;
      rem_req.start    = 1'b0;
      rem_req.dividend = mag63(h_ff);
      rem_req.divisor  = r_ff[62:0];
      case (state_ff)
         S_IDLE: begin
            if (take && req_last_sample) begin
               lo_in  = low_fixed_ff ?
                        {{(64-SAMPLE_WIDTH){low_value_ff[SAMPLE_WIDTH-1]}}, low_value_ff} :
                        {{(64-SAMPLE_WIDTH){min_now[SAMPLE_WIDTH-1]}}, min_now};
               hi_in  = high_fixed_ff ?
                        {{(64-SAMPLE_WIDTH){high_value_ff[SAMPLE_WIDTH-1]}}, high_value_ff} :
                        {{(64-SAMPLE_WIDTH){max_now[SAMPLE_WIDTH-1]}}, max_now};
               lof_in = low_fixed_ff;
               hif_in = high_fixed_ff;
               state_in = S_SETUP;
            end
         end
         S_SETUP: begin
            swp_in  = 1'b0;
            pass_in = '0;
            e_in    = '0;
            err_in  = 1'b0;
            state_in = S_INIT;
            if (quantum_fixed_ff) begin
               err_in = (delta_q == 68'sd0) || (qv == 64'sd0) ||
                        (delta_q[67] != qv[63]);
               zl_in = lo_ff;
               zh_in = hi_ff;
               state_in = S_FIN;
            end else if (hi_ff < lo_ff) begin
               // reversed bounds: work on the swapped pair
               lo_in  = hi_ff;
               hi_in  = lo_ff;
               lof_in = hif_ff;
               hif_in = lof_ff;
               swp_in = 1'b1;
            end else if (hi_ff == lo_ff) begin
               if (hi_ff > 64'sd0) begin
                  hi_in = hi_ff <<< 1;
                  lo_in = '0;
               end else if (lo_ff < 64'sd0) begin
                  lo_in = lo_ff <<< 1;
                  hi_in = '0;
               end else begin
                  hi_in = ONE_Q16;
                  lo_in = -ONE_Q16;
               end
            end
         end
         S_INIT: begin
            d_in = hi_ff - lo_ff;
            r_in = ONE_Q16;
            l_in = lo_ff;
            h_in = hi_ff;
            e_in = '0;
            state_in = S_SCALE;
         end
         S_SCALE: begin
            if (d_ff < SCALE_LIMIT && e_ff < MAX_EXP) begin
               d_in = sat10(d_ff);
               l_in = sat10(l_ff);
               h_in = sat10(h_ff);
               e_in = e_ff + 3'd1;
            end else begin
               state_in = S_RSRCH;
            end
         end
         S_RSRCH: begin
            if (r10 < d_ff) begin
               r_in = r10;
            end else begin
               if (r2 >= d_ff) r_in = r_ff >>> 1;
               else if (r5 < d_ff) r_in = r2;
               state_in = S_HSTART;
            end
         end
         S_HSTART: begin
            if (hif_ff) begin
               zh_in = h_ff;
               state_in = S_LSTART;
            end else begin
               rem_req.start = 1'b1;
               state_in = S_HWAIT;
            end
         end
         S_HWAIT: begin
            if (rem_rsp.done) begin
               // round up: toward zero for negatives, away for positives
               if (!ax[67] && ax != 68'sd0 && remx != 68'sd0) zh_in = sat68(ax - remx + rx);
               else if (ax[67]) zh_in = sat68(ax + remx);
               else zh_in = h_ff;
               state_in = S_LSTART;
            end
         end
         S_LSTART: begin
            if (lof_ff) begin
               zl_in = l_ff;
               state_in = S_CHECK;
            end else begin
               rem_req.start    = 1'b1;
               rem_req.dividend = mag63(l_ff);
               state_in = S_LWAIT;
            end
         end
         S_LWAIT: begin
            if (rem_rsp.done) begin
               if (ax[67] && remx != 68'sd0) zl_in = sat68(ax + remx - rx);
               else zl_in = sat68(ax - remx);
               state_in = S_CHECK;
            end
         end
         S_CHECK: begin
            state_in = S_FIN;
            if (pass_ff != MAX_PASS) begin
               // a bound within one step of zero snaps to zero
               if (!lof_ff && zl_ff <= r_ff && zl_ff > 64'sd0) begin
                  lo_in = '0;
                  pass_in = pass_ff + 2'd1;
                  state_in = S_INIT;
               end else if (!hif_ff && zh_ff >= -r_ff && zh_ff < 64'sd0) begin
                  hi_in = '0;
                  pass_in = pass_ff + 2'd1;
                  state_in = S_INIT;
               end
            end
         end
         S_FIN: begin
            if (quantum_fixed_ff) begin
               out_low_in  = zl_ff[62:0];
               out_high_in = zh_ff[62:0];
               out_step_in = qv[62:0];
               out_exp_in  = '0;
            end else if (swp_ff) begin
               out_low_in  = zh_ff[62:0];
               out_high_in = zl_ff[62:0];
               out_step_in = 63'(-r_ff);
               out_exp_in  = e_ff;
            end else begin
               out_low_in  = zl_ff[62:0];
               out_high_in = zh_ff[62:0];
               out_step_in = r_ff[62:0];
               out_exp_in  = e_ff;
            end
            out_err_in   = quantum_fixed_ff && err_ff;
            rsp_valid_in = 1'b1;
            state_in     = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         pass_ff      <= '0;
         e_ff         <= '0;
         err_ff       <= 1'b0;
         swp_ff       <= 1'b0;
         lof_ff       <= 1'b0;
         hif_ff       <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         pass_ff      <= pass_in;
         e_ff         <= e_in;
         err_ff       <= err_in;
         swp_ff       <= swp_in;
         lof_ff       <= lof_in;
         hif_ff       <= hif_in;
      end
      lo_ff       <= lo_in;
      hi_ff       <= hi_in;
      d_ff        <= d_in;
      r_ff        <= r_in;
      l_ff        <= l_in;
      h_ff        <= h_in;
      zl_ff       <= zl_in;
      zh_ff       <= zh_in;
      out_low_ff  <= out_low_in;
      out_high_ff <= out_high_in;
      out_step_ff <= out_step_in;
      out_exp_ff  <= out_exp_in;
      out_err_ff  <= out_err_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_axis_low       = out_low_ff;
   assign rsp_axis_high      = out_high_ff;
   assign rsp_tick_step      = out_step_ff;
   assign rsp_scale_exponent = out_exp_ff;
   assign rsp_range_error    = out_err_ff;

   a_err_no_scale: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_range_error |-> rsp_scale_exponent == 3'd0)
      else $error("range error with nonzero scale");

   a_rem_done_waited: assert property (@(posedge clock) disable iff (reset)
      rem_rsp.done |-> (state_ff == S_HWAIT || state_ff == S_LWAIT))
      else $error("remainder finished while not awaited");

   a_pass_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_INIT |-> pass_ff <= MAX_PASS)
      else $error("too many limit passes");

   a_busy_not_ready: assert property (@(posedge clock) disable iff (reset)
      state_ff != S_IDLE |-> !req_ready)
      else $error("item taken during limit computation");

endmodule

/* tb/axis_range_autoscale_test.sv */
`timescale 1ns / 1ps
module axis_range_autoscale_test;
   import ara_pkg::*;

   localparam longint AXIS_MAX   = (64'sd1 <<< 62) - 1;
   localparam longint AXIS_MIN   = -AXIS_MAX - 1;
   localparam longint Q1         = 65536;
   localparam int     CYCLE_CAP  = 3000000;
   localparam int     SETTLE     = 600;

   typedef struct {
      logic signed [62:0] lo;
      logic signed [62:0] hi;
      logic signed [62:0] step;
      logic [2:0]         ex;
      logic               err;
   } axis_res_type;

   typedef struct {
      int                 phase;
      logic signed [31:0] sample;
      logic               last;
      bit                 typed;
      axis_res_type       res;
   } stim_row_type;

   logic                     clock = 0;
   logic                     reset = 1;
   logic                     req_valid = 0;
   logic                     req_ready;
   logic signed [31:0]       req_sample_value = 0;
   logic                     req_last_sample = 0;
   logic                     rsp_valid;
   logic                     rsp_ready = 0;
   logic signed [62:0]       rsp_axis_low;
   logic signed [62:0]       rsp_axis_high;
   logic signed [62:0]       rsp_tick_step;
   logic [2:0]               rsp_scale_exponent;
   logic                     rsp_range_error;
   logic                     csr_we = 0;
   logic [2:0]               csr_index = 0;
   logic [31:0]              csr_wdata = 0;

   axis_res_type pending_axes[$];
   int        fail_count = 0;
   int        cycle_count = 0;
   bit        quiet = 0;
   bit        hold_req = 0;
   int        hold_left = 0;

   // shadow of the block's registers and data-set state
   bit     lo_fix, hi_fix, q_fix;
   longint lo_val, hi_val, q_val;
   longint run_min, run_max;

   axis_range_autoscale i_dut (.*);

   initial begin
      forever #1 clock = ~clock;
   end

   function automatic longint clip(input longint v);
      if (v > AXIS_MAX) return AXIS_MAX;
      if (v < AXIS_MIN) return AXIS_MIN;
      return v;
   endfunction

   function automatic longint floor_to(input longint a, input longint r);
      longint q;
      q = a / r;
      if (a % r != 0 && a < 0) q--;
      return clip(q * r);
   endfunction

   function automatic longint ceil_to(input longint a, input longint r);
      longint q;
      q = a / r;
      if (a % r != 0 && a > 0) q++;
      return clip(q * r);
   endfunction

   function automatic void fit_limits(input bit lof, input bit hif, input longint lo_in,
                                      input longint hi_in, output longint zl,
                                      output longint zh, output longint quant,
                                      output int ex);
      longint lo, hi, delta, s, d, r;
      int     e;
      lo = lo_in;
      hi = hi_in;
      for (int pass = 0; pass < 3; pass++) begin
         delta = hi - lo;
         s = 1;
         e = 0;
         r = Q1;
         while (delta * s < 10 * Q1 && e < 6) begin
            s = s * 10;
            e++;
         end
         d = delta * s;
         while (10 * r < d) r = r * 10;
         if (2 * r >= d) r = r / 2;
         else if (5 * r < d) r = r * 2;
         zh = hif ? clip(hi * s) : ceil_to(clip(hi * s), r);
         zl = lof ? clip(lo * s) : floor_to(clip(lo * s), r);
         quant = r;
         ex = e;
         // bound within one step of zero snaps to zero and is redone
         if (!lof && zl <= r && zl > 0) begin
            lo = 0;
            continue;
         end
         if (!hif && zh >= -r && zh < 0) begin
            hi = 0;
            continue;
         end
         break;
      end
   endfunction

   function automatic bit predict_axes(input longint v, input bit last,
                                       output axis_res_type res);
      longint lb, ub, zl, zh, q, t, delta;
      int     e;
      bit     err;
      if (!lo_fix && v < run_min) run_min = v;
      if (!hi_fix && v > run_max) run_max = v;
      if (!last) return 0;
      lb = lo_fix ? lo_val : run_min;
      ub = hi_fix ? hi_val : run_max;
      run_min = 64'sd2147483647;
      run_max = -64'sd2147483648;
      e = 0;
      err = 0;
      if (q_fix) begin
         delta = ub - lb;
         if (delta == 0 || q_val == 0 || ((delta < 0) != (q_val < 0))) err = 1;
         zl = lb;
         zh = ub;
         q = q_val;
      end else if (ub < lb) begin
         // reversed bounds: swap, compute, swap back, negate the step
         fit_limits(hi_fix, lo_fix, ub, lb, zl, zh, q, e);
         t = zl;
         zl = zh;
         zh = t;
         q = -q;
      end else begin
         if (ub == lb) begin
            if (ub > 0) begin
               ub = 2 * ub;
               lb = 0;
            end else if (lb < 0) begin
               lb = 2 * lb;
               ub = 0;
            end else begin
               ub = Q1;
               lb = -Q1;
            end
         end
         fit_limits(lo_fix, hi_fix, lb, ub, zl, zh, q, e);
      end
      res.lo = 63'(clip(zl));
      res.hi = 63'(clip(zh));
      res.step = 63'(clip(q));
      res.ex = 3'(e);
      res.err = err;
      return 1;
   endfunction

   task automatic write_reg(input logic [2:0] idx, input logic [31:0] data);
      csr_we <= 1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
   endtask

   task automatic set_config(input bit lf, input logic [31:0] lv, input bit hf,
                             input logic [31:0] hv, input bit qf, input logic [31:0] qv);
      write_reg(REG_LOW_FIXED, {31'd0, lf});
      write_reg(REG_LOW_VALUE, lv);
      write_reg(REG_HIGH_FIXED, {31'd0, hf});
      write_reg(REG_HIGH_VALUE, hv);
      write_reg(REG_QUANTUM_FIXED, {31'd0, qf});
      write_reg(REG_QUANTUM_VALUE, qv);
      csr_we <= 0;
      @(posedge clock);
      lo_fix = lf;
      hi_fix = hf;
      q_fix = qf;
      lo_val = longint'($signed(lv));
      hi_val = longint'($signed(hv));
      q_val = longint'($signed(qv));
   endtask

   // waits for every expected result, then lets the block settle
   task automatic drain();
      req_valid <= 0;
      @(posedge clock);
      while (pending_axes.size() > 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic send_sample(input logic [31:0] v, input logic last, input bit typed,
                              input axis_res_type typed_res);
      axis_res_type res;
      while (!quiet && $urandom_range(99) < 8) begin
         req_valid <= 0;
         @(posedge clock);
      end
      req_valid <= 1;
      req_sample_value <= v;
      req_last_sample <= last;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      if (predict_axes(longint'($signed(v)), last, res))
         pending_axes.push_back(typed ? typed_res : res);
   endtask

   function automatic logic [31:0] rand_value();
      case ($urandom_range(5))
         0: return $urandom;
         1: return $urandom_range(200) - 100;
         2: return ($urandom_range(2000) - 1000) << 16;
         3: return $urandom_range(1) ? 32'h7fffffff : 32'h80000000;
         default: return ($urandom_range(1 << 22)) - (1 << 21);
      endcase
   endfunction

   task automatic apply_directed_phase(input int phase);
      case (phase)
         0: set_config(0, 0, 0, 0, 0, 0);
         1: set_config(0, 0, 0, 0, 1, 0);
         2: set_config(1, 32'h80000000, 1, 32'h7fffffff, 0, 0);
         default: set_config(1, 100 << 16, 1, -(100 << 16), 0, 0);
      endcase
   endtask

   stim_row_type directed[$];
   axis_res_type none_res;

   function automatic stim_row_type row(input int ph, input logic [31:0] v, input logic last);
      stim_row_type r;
      r.phase = ph;
      r.sample = v;
      r.last = last;
      r.typed = 0;
      return r;
   endfunction

   // receiver: random stalls plus one long hold-off
   initial begin
      forever begin
         @(posedge clock);
         if (rsp_valid && rsp_ready) begin
            if (pending_axes.size() == 0) begin
               $error("unexpected result item");
               fail_count++;
            end else begin
               axis_res_type ex;
               ex = pending_axes.pop_front();
               if (rsp_axis_low !== ex.lo) begin
                  $error("axis_low expected %0d actual %0d", ex.lo, rsp_axis_low);
                  fail_count++;
               end
               if (rsp_axis_high !== ex.hi) begin
                  $error("axis_high expected %0d actual %0d", ex.hi, rsp_axis_high);
                  fail_count++;
               end
               if (rsp_tick_step !== ex.step) begin
                  $error("tick_step expected %0d actual %0d", ex.step, rsp_tick_step);
                  fail_count++;
               end
               if (rsp_scale_exponent !== ex.ex) begin
                  $error("scale_exponent expected %0d actual %0d", ex.ex, rsp_scale_exponent);
                  fail_count++;
               end
               if (rsp_range_error !== ex.err) begin
                  $error("range_error expected %0d actual %0d", ex.err, rsp_range_error);
                  fail_count++;
               end
            end
         end
         if (hold_req) begin
            hold_req = 0;
            hold_left = 4000;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 0;
         end else begin
            rsp_ready <= quiet || $urandom_range(99) >= 8;
         end
      end
   end

   initial begin
      forever begin
         @(posedge clock);
         cycle_count++;
         if (cycle_count > CYCLE_CAP) begin
            $display("axis_range_autoscale_test: FAIL");
            $finish;
         end
      end
   end

   initial begin
      int        cur_phase;
      int        sent;
      stim_row_type r;
      bit        lf, hf, qf;
      logic [31:0] lv, hv, qv;
      int        set_len;
      run_min = 64'sd2147483647;
      run_max = -64'sd2147483648;
      lo_fix = 0;
      hi_fix = 0;
      q_fix = 0;
      lo_val = 0;
      hi_val = 0;
      q_val = 0;

      r = row(0, 0, 1);
      r.typed = 1;
      r.res = '{lo: -655360, hi: 655360, step: 327680, ex: 1, err: 0};
      directed.push_back(r);
      directed.push_back(row(0, 32'h7fffffff, 0));
      directed.push_back(row(0, 32'h80000000, 1));
      directed.push_back(row(0, 5 << 16, 1));
      directed.push_back(row(0, -(3 << 16), 1));
      directed.push_back(row(0, 32'h7fffffff, 1));
      directed.push_back(row(0, 32'h80000000, 1));
      directed.push_back(row(0, 1 << 16, 0));
      directed.push_back(row(0, 9 << 16, 1));
      directed.push_back(row(0, -(9 << 16), 0));
      directed.push_back(row(0, -(1 << 16), 1));
      directed.push_back(row(0, 3, 0));
      directed.push_back(row(0, 7, 1));
      r = row(1, 5, 1);
      r.typed = 1;
      r.res = '{lo: 5, hi: 5, step: 0, ex: 0, err: 1};
      directed.push_back(r);
      directed.push_back(row(1, 2 << 16, 0));
      directed.push_back(row(1, 9 << 16, 1));
      directed.push_back(row(2, 0, 1));
      directed.push_back(row(2, 12345, 1));
      directed.push_back(row(3, 7, 1));
      directed.push_back(row(3, -7, 1));

      repeat (8) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      cur_phase = 0;
      foreach (directed[i]) begin
         if (directed[i].phase != cur_phase) begin
            drain();
            cur_phase = directed[i].phase;
            apply_directed_phase(cur_phase);
         end
         send_sample(directed[i].sample, directed[i].last, directed[i].typed,
                     directed[i].res);
      end
      drain();

      sent = 0;
      for (int ph = 0; sent < 1750; ph++) begin
         if (ph % 10 == 0) begin
            lf = 0; hf = 0; qf = 0; lv = 0; hv = 0; qv = 0;
         end else begin
            lf = $urandom_range(99) < 30;
            hf = $urandom_range(99) < 30;
            qf = $urandom_range(99) < 15;
            lv = rand_value();
            hv = rand_value();
            qv = rand_value();
            if (ph % 7 == 3) begin
               lv = 32'h80000000;
               hv = 32'h7fffffff;
               qv = $urandom_range(1) ? 32'h7fffffff : 32'h80000000;
            end
         end
         set_config(lf, lv, hf, hv, qf, qv);
         quiet = (ph % 9 == 4);
         if (ph == 5) hold_req = 1;
         for (int k = 0; k < 40; k++) begin
            set_len = $urandom_range(99) < 80 ? $urandom_range(1, 5) : $urandom_range(6, 14);
            for (int j = 0; j < set_len; j++) begin
               send_sample(rand_value(), j == set_len - 1, 0, none_res);
               sent++;
            end
         end
         drain();
         quiet = 0;
      end

      if (fail_count == 0 && pending_axes.size() == 0) begin
         $display("axis_range_autoscale_test: PASS");
      end else begin
         $display("axis_range_autoscale_test: FAIL");
      end
      $finish;
   end

endmodule
